### src/scaled_matrix_multiply_add_defines.svh
// Assertion macros for the top module.
`ifndef SCALED_MATRIX_MULTIPLY_ADD_DEFINES_SVH
`define SCALED_MATRIX_MULTIPLY_ADD_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SMMA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SMMA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/smma_pkg.sv
`timescale 1ns / 1ps
package smma_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 12;

	localparam int IDX_W  = 3;
	localparam int CNT_W  = 4;
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
	localparam int REG_W  = 3;

	// Input commands
	localparam logic [1:0] CMD_WRITE_A = 2'd0;
	localparam logic [1:0] CMD_WRITE_B = 2'd1;
	localparam logic [1:0] CMD_WRITE_C = 2'd2;
	localparam logic [1:0] CMD_START   = 2'd3;

	// Configuration register indexes
	localparam logic [REG_W-1:0] REG_ROW_COUNT    = 3'd0;
	localparam logic [REG_W-1:0] REG_INNER_COUNT  = 3'd1;
	localparam logic [REG_W-1:0] REG_COLUMN_COUNT = 3'd2;
	localparam logic [REG_W-1:0] REG_ALPHA_GAIN   = 3'd3;
	localparam logic [REG_W-1:0] REG_BETA_GAIN    = 3'd4;

	typedef logic [DIM_W-1:0]             dim_idx_t;
	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [ACC_W-1:0]      acc_t;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [IDX_W-1:0]       row_index;
		logic [IDX_W-1:0]       col_index;
		logic signed [DATA_WIDTH-1:0] elem_value;
	} smma_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]       out_row;
		logic [IDX_W-1:0]       out_col;
		logic signed [DATA_WIDTH-1:0] out_value;
		logic                   saturated;
		logic                   last_result;
	} smma_out_t;

	// Element of A travelling down the cell row, tagged with its inner index
	typedef struct packed {
		logic                   valid;
		logic [DIM_W-1:0]       p;
		logic signed [DATA_WIDTH-1:0] a;
	} smma_link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FEED,
		ST_DRAIN,
		ST_RD,
		ST_MUL,
		ST_FIN
	} smma_state_t;

endpackage

### src/smma_ram.sv
`timescale 1ns / 1ps
module smma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/smma_cell.sv
`timescale 1ns / 1ps
module smma_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                b_we,
	input  smma_pkg::dim_idx_t  b_row,
	input  smma_pkg::data_t     b_data,
	input  logic                clear,
	input  smma_pkg::smma_link_t link_in,
	output smma_pkg::smma_link_t link_out,
	output smma_pkg::acc_t      acc
);
	import smma_pkg::*;

	data_t                      b_q [MAX_DIM];
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       prod_v_s1;
	acc_t                       acc_q;
	logic                       link_v_q;
	dim_idx_t                   link_p_q;
	data_t                      link_a_q;

	// Hold this cell's column of B
	always_ff @(posedge clk) begin
		if (b_we) begin
			b_q[b_row] <= b_data;
		end
	end

	// Pass the A element on and form its product with B
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_v_q  <= 1'b0;
			prod_v_s1 <= 1'b0;
		end else begin
			link_v_q  <= link_in.valid;
			prod_v_s1 <= link_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		link_p_q <= link_in.p;
		link_a_q <= link_in.a;
		prod_s1  <= link_in.a * b_q[link_in.p];
	end

	// Accumulate products for this column
	always_ff @(posedge clk) begin
		if (clear) begin
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	assign link_out.valid = link_v_q;
	assign link_out.p     = link_p_q;
	assign link_out.a     = link_a_q;
	assign acc            = acc_q;

endmodule

### src/scaled_matrix_multiply_add.sv
`timescale 1ns / 1ps
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------
// in        | in_valid / in_ready  | in_data   (cmd, row, col, element)
// out       | out_valid / out_ready| out_data  (row, col, value, sat, last)
// cfg       | cfg_we               | cfg_index, cfg_data (no read-back)
//
// Each write transaction (A, B or C element) is stored when it is accepted.
// A start transaction walks the result row by row: per row, it feeds A down
// the row of column cells, drains the cell pipeline, then runs the shared
// alpha/beta unit once per column.
// A stalled out channel holds the walk in its final step; in_ready is low
// for the whole run. Reset clears control state and sets the configuration
// to its defaults.
module scaled_matrix_multiply_add (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  smma_pkg::smma_in_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output smma_pkg::smma_out_t   out_data,
	input  logic                  cfg_we,
	input  logic [smma_pkg::REG_W-1:0]      cfg_index,
	input  logic [smma_pkg::DATA_WIDTH-1:0] cfg_data
);
	import smma_pkg::*;

	`include "scaled_matrix_multiply_add_defines.svh"

	localparam int DRAIN_LEN = MAX_DIM + 3;
	localparam int DRN_W     = $clog2(DRAIN_LEN);
	localparam int S_W       = ACC_W - FRAC_BITS;
	localparam int AB_W      = DATA_WIDTH + S_W;
	localparam int BC_W      = PROD_W;
	localparam int T1_W      = AB_W - FRAC_BITS;
	localparam int T2_W      = BC_W - FRAC_BITS;
	localparam int SUM_W     = ((T1_W > T2_W) ? T1_W : T2_W) + 1;
	localparam logic signed [SUM_W-1:0] VMAX = SUM_W'(2 ** (DATA_WIDTH - 1) - 1);
	localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);
	localparam logic [IDX_W:0] DIM_LIM = (IDX_W + 1)'(MAX_DIM);

	function automatic logic [CNT_W-1:0] dim_of(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] res;
		res = cnt;
		if (cnt == '0) begin
			res = CNT_W'(1);
		end else if (cnt > CNT_W'(MAX_DIM)) begin
			res = CNT_W'(MAX_DIM);
		end
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
						      input logic [IDX_W-1:0] col);
		return ADDR_W'(row * MAX_DIM + col);
	endfunction

	// Configuration
	logic [CNT_W-1:0] row_count_q, inner_count_q, column_count_q;
	data_t            alpha_q, beta_q;

	// Control
	smma_state_t      state_q, state_d;
	logic [CNT_W-1:0] m_q, k_q, n_q;
	dim_idx_t         i_q, j_q, p_q;
	logic [DRN_W-1:0] drain_q;
	logic             feed_v_s1;
	dim_idx_t         feed_p_s1;

	// Datapath
	logic                    in_fire, wr_ok, fire_w;
	logic                    p_last, i_last, j_last, drain_done;
	logic                    acc_clear, feed_issue;
	logic [ADDR_W-1:0]       in_addr, a_raddr, c_raddr, c_waddr;
	logic                    a_we, c_we;
	logic [DATA_WIDTH-1:0]   a_rdata, c_rdata, c_wdata;
	smma_link_t              head_w;
	smma_link_t              link_w [MAX_DIM];
	acc_t                    acc_w [MAX_DIM];
	logic signed [S_W-1:0]   s_w;
	logic signed [AB_W-1:0]  prod_a_s1;
	logic signed [BC_W-1:0]  prod_b_s1;
	logic signed [SUM_W-1:0] t1_w, t2_w, tot_w;
	data_t                   res_w;
	logic                    sat_w;
	logic                    out_valid_q;
	smma_out_t               out_q;

	assign in_fire  = in_valid && in_ready;
	assign wr_ok    = in_fire && (in_data.cmd != CMD_START) &&
			  ({1'b0, in_data.row_index} < DIM_LIM) &&
			  ({1'b0, in_data.col_index} < DIM_LIM);
	assign in_addr  = addr_of(in_data.row_index, in_data.col_index);
	assign fire_w   = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	assign p_last     = (CNT_W'(p_q) + CNT_W'(1)) == k_q;
	assign i_last     = (CNT_W'(i_q) + CNT_W'(1)) == m_q;
	assign j_last     = (CNT_W'(j_q) + CNT_W'(1)) == n_q;
	assign drain_done = drain_q == DRN_W'(DRAIN_LEN - 1);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CNT_W'(8);
			inner_count_q  <= CNT_W'(8);
			column_count_q <= CNT_W'(8);
			alpha_q        <= DATA_WIDTH'(4096);
			beta_q         <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data[CNT_W-1:0];
				REG_INNER_COUNT:  inner_count_q  <= cfg_data[CNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= cfg_data[CNT_W-1:0];
				REG_ALPHA_GAIN:   alpha_q        <= cfg_data;
				REG_BETA_GAIN:    beta_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_data.cmd == CMD_START) state_d = ST_FEED;
			end
			ST_FEED: begin
				if (p_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_done) state_d = ST_RD;
			end
			ST_RD:  state_d = ST_MUL;
			ST_MUL: state_d = ST_FIN;
			ST_FIN: begin
				if (fire_w) begin
					if (!j_last) state_d = ST_RD;
					else if (i_last) state_d = ST_IDLE;
					else state_d = ST_FEED;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		in_ready   = 1'b0;
		feed_issue = 1'b0;
		acc_clear  = 1'b0;
		a_we       = 1'b0;
		c_we       = 1'b0;
		c_waddr    = in_addr;
		c_wdata    = in_data.elem_value;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				a_we     = wr_ok && (in_data.cmd == CMD_WRITE_A);
				c_we     = wr_ok && (in_data.cmd == CMD_WRITE_C);
			end
			ST_FEED: begin
				feed_issue = 1'b1;
				acc_clear  = (p_q == '0);
			end
			ST_FIN: begin
				c_we    = fire_w;
				c_waddr = addr_of(IDX_W'(i_q), IDX_W'(j_q));
				c_wdata = res_w;
			end
			default: ;
		endcase
	end

	assign a_raddr = addr_of(IDX_W'(i_q), IDX_W'(p_q));
	assign c_raddr = addr_of(IDX_W'(i_q), IDX_W'(j_q));

	// Advance state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_q       <= '0;
			k_q       <= '0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			p_q       <= '0;
			drain_q   <= '0;
			feed_v_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			feed_v_s1 <= feed_issue;
			case (state_q)
				ST_IDLE: begin
					m_q <= dim_of(row_count_q);
					k_q <= dim_of(inner_count_q);
					n_q <= dim_of(column_count_q);
					i_q <= '0;
					p_q <= '0;
				end
				ST_FEED: begin
					p_q     <= p_q + DIM_W'(1);
					drain_q <= '0;
				end
				ST_DRAIN: begin
					drain_q <= drain_q + DRN_W'(1);
					j_q     <= '0;
				end
				ST_FIN: begin
					if (fire_w) begin
						j_q <= j_q + DIM_W'(1);
						p_q <= '0;
						if (j_last) i_q <= i_q + DIM_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		feed_p_s1 <= p_q;
	end

	// Element stores
	smma_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (in_addr),
		.wdata (in_data.elem_value),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	smma_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_DIM * MAX_DIM)) u_ram_c (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// Row of column cells; A enters at cell 0 and moves one cell a cycle
	assign head_w.valid = feed_v_s1;
	assign head_w.p     = feed_p_s1;
	assign head_w.a     = a_rdata;

	for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
		smma_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.b_we     (wr_ok && (in_data.cmd == CMD_WRITE_B) &&
				   ({1'b0, in_data.col_index} == (IDX_W + 1)'(g))),
			.b_row    (DIM_W'(in_data.row_index)),
			.b_data   (in_data.elem_value),
			.clear    (acc_clear),
			.link_in  ((g == 0) ? head_w : link_w[(g == 0) ? 0 : g - 1]),
			.link_out (link_w[g]),
			.acc      (acc_w[g])
		);
	end

	// Scale the sum and the old C element
	assign s_w = S_W'(acc_w[j_q] >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		prod_a_s1 <= alpha_q * s_w;
		prod_b_s1 <= beta_q * $signed(c_rdata);
	end

	// Add and saturate
	always_comb begin
		t1_w  = SUM_W'(prod_a_s1 >>> FRAC_BITS);
		t2_w  = SUM_W'(prod_b_s1 >>> FRAC_BITS);
		tot_w = t1_w + t2_w;
		sat_w = 1'b0;
		res_w = DATA_WIDTH'(tot_w);
		if (tot_w > VMAX) begin
			res_w = DATA_WIDTH'(VMAX);
			sat_w = 1'b1;
		end else if (tot_w < VMIN) begin
			res_w = DATA_WIDTH'(VMIN);
			sat_w = 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_w) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_w) begin
			out_q.out_row     <= IDX_W'(i_q);
			out_q.out_col     <= IDX_W'(j_q);
			out_q.out_value   <= res_w;
			out_q.saturated   <= sat_w;
			out_q.last_result <= i_last && j_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SMMA_ASSERT_NXT(a_feed_to_drain, (state_q == ST_FEED) && p_last,
		state_q == ST_DRAIN, "feed did not stop after the last inner index")
	`SMMA_ASSERT_IMP(a_out_from_fin, $rose(out_valid_q),
		$past(state_q) == ST_FIN, "result loaded outside the final step")
	`SMMA_ASSERT_NXT(a_last_ends_run, fire_w && i_last && j_last,
		state_q == ST_IDLE, "run did not end on the last element")
	`SMMA_ASSERT_IMP(a_head_from_feed, feed_v_s1,
		$past(state_q) == ST_FEED, "cell row fed outside the feed phase")
	`SMMA_ASSERT_IMP(a_tail_in_walk, link_w[MAX_DIM-1].valid,
		(state_q == ST_FEED) || (state_q == ST_DRAIN), "cell row still busy after drain")

endmodule
